>>> src/imufa_pkg.sv
package imufa_pkg;

  localparam int IdW   = 11;
  localparam int DutyW = 10;
  localparam int WordW = 16;
  localparam int BandW = 3;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 11;
  localparam int StepW = 4;
  localparam int MulAW = 32;
  localparam int MulBW = 18;
  localparam int ProdW = MulAW + MulBW;

  localparam logic [CfgIdxW-1:0] CFG_ACCEL_ID  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_GYRO_ID   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TEMP_ID   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_FULL_DUTY = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DUTY_STEP = 3'd4;

  localparam logic [IdW-1:0]   RST_ACCEL_ID  = 11'd848;
  localparam logic [IdW-1:0]   RST_GYRO_ID   = 11'd849;
  localparam logic [IdW-1:0]   RST_TEMP_ID   = 11'd850;
  localparam logic [DutyW-1:0] RST_FULL_DUTY = 10'd1000;
  localparam logic [DutyW-1:0] RST_DUTY_STEP = 10'd200;

  localparam logic [3:0] DATA_LEN = 4'd8;

  localparam logic [2:0] PART_ACCEL = 3'b001;
  localparam logic [2:0] PART_RATE  = 3'b010;
  localparam logic [2:0] PART_TEMP  = 3'b100;
  localparam logic [2:0] PART_ALL   = 3'b111;

  // sequencer steps: squares of ax, ay, az, one idle slot, then five thresholds
  localparam logic [StepW-1:0] STEP_SQ_X    = 4'd0;
  localparam logic [StepW-1:0] STEP_SQ_Y    = 4'd1;
  localparam logic [StepW-1:0] STEP_SQ_Z    = 4'd2;
  localparam logic [StepW-1:0] STEP_GAP     = 4'd3;
  localparam logic [StepW-1:0] STEP_THR0    = 4'd4;
  localparam logic [StepW-1:0] STEP_THR4    = 4'd8;
  localparam logic [StepW-1:0] STEP_LAST    = 4'd9;

  localparam logic [BandW-1:0] BAND_MAX = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic             file;
    logic             mul_en;
    logic             acc_en;
    logic [StepW-1:0] step;
    logic             finish;
  } cmd_t;

  typedef struct packed {
    logic complete;
    logic out_busy;
  } sts_t;

  function automatic logic [MulBW-1:0] tilt_limit(input logic [2:0] idx);
    logic [MulBW-1:0] t;
    unique case (idx)
      3'd0:    t = 18'd8682;
      3'd1:    t = 18'd21845;
      3'd2:    t = 18'd46143;
      3'd3:    t = 18'd93079;
      3'd4:    t = 18'd196608;
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [WordW:0] mag16(input logic [WordW-1:0] w);
    logic [WordW:0] s;
    s = {w[WordW-1], w};
    return w[WordW-1] ? (~s + 1'b1) : s;
  endfunction

endpackage

>>> src/imufa_ctrl.sv
module imufa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  imufa_pkg::sts_t sts,
  output imufa_pkg::cmd_t cmd
);
  import imufa_pkg::*;

  state_t           state_r, state_nxt;
  logic [StepW-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    cmd        = '0;
    cmd.step   = step_r;
    in_stall   = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.file = 1'b1;
          if (sts.complete) begin
            state_nxt = ST_MUL;
            step_nxt  = STEP_SQ_X;
          end
        end
      end
      ST_MUL: begin
        cmd.mul_en = (step_r != STEP_GAP) && (step_r <= STEP_THR4);
        cmd.acc_en = (step_r != STEP_SQ_X) && (step_r != STEP_THR0);
        if (step_r == STEP_LAST) begin
          state_nxt = ST_FIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> src/imufa_datapath.sv
module imufa_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  imufa_pkg::cmd_t                cmd,
  output imufa_pkg::sts_t                sts,
  input  logic                           cfg_we,
  input  logic [imufa_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [imufa_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic [imufa_pkg::IdW-1:0]      in_frame_id,
  input  logic                           in_extended_flag,
  input  logic                           in_remote_flag,
  input  logic [3:0]                     in_length_code,
  input  logic [15:0]                    in_sequence_word,
  input  logic signed [15:0]             in_first_word,
  input  logic signed [15:0]             in_second_word,
  input  logic signed [15:0]             in_third_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [15:0]                    out_sample_number,
  output logic signed [15:0]             out_accel_x,
  output logic signed [15:0]             out_accel_y,
  output logic signed [15:0]             out_accel_z,
  output logic signed [15:0]             out_rate_x,
  output logic signed [15:0]             out_rate_y,
  output logic signed [15:0]             out_rate_z,
  output logic signed [15:0]             out_temp_word,
  output logic [imufa_pkg::BandW-1:0]    out_tilt_band,
  output logic [imufa_pkg::DutyW-1:0]    out_motor_duty
);
  import imufa_pkg::*;

  logic [IdW-1:0]   accel_id_r, gyro_id_r, temp_id_r;
  logic [DutyW-1:0] full_duty_r, duty_step_r;

  logic [WordW-1:0] rec_num_r, rec_num_nxt;
  logic [WordW-1:0] rec_ax_r, rec_ay_r, rec_az_r, rec_ax_nxt, rec_ay_nxt, rec_az_nxt;
  logic [WordW-1:0] rec_rx_r, rec_ry_r, rec_rz_r, rec_rx_nxt, rec_ry_nxt, rec_rz_nxt;
  logic [WordW-1:0] rec_temp_r, rec_temp_nxt;
  logic [2:0]       have_r, have_nxt;
  logic [2:0]       have_fill;

  logic is_accel, is_gyro, is_temp, frame_ok, restart;

  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [WordW:0]   sq_mag;
  logic [ProdW-1:0] prod_r;
  logic [MulAW-1:0] h_r, v_r;
  logic [BandW-1:0] band_r, band_fin;
  logic [12:0]      drop;
  logic [DutyW-1:0] duty_fin;
  logic             out_valid_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_id_r  <= RST_ACCEL_ID;
      gyro_id_r   <= RST_GYRO_ID;
      temp_id_r   <= RST_TEMP_ID;
      full_duty_r <= RST_FULL_DUTY;
      duty_step_r <= RST_DUTY_STEP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACCEL_ID:  accel_id_r  <= cfg_wdata;
        CFG_GYRO_ID:   gyro_id_r   <= cfg_wdata;
        CFG_TEMP_ID:   temp_id_r   <= cfg_wdata;
        CFG_FULL_DUTY: full_duty_r <= cfg_wdata[DutyW-1:0];
        CFG_DUTY_STEP: duty_step_r <= cfg_wdata[DutyW-1:0];
        default: ;
      endcase
    end
  end

  // frame classification
  always_comb begin
    is_accel = (in_frame_id == accel_id_r);
    is_gyro  = !is_accel && (in_frame_id == gyro_id_r);
    is_temp  = !is_accel && !is_gyro && (in_frame_id == temp_id_r);
    frame_ok = !in_extended_flag && !in_remote_flag && (in_length_code == DATA_LEN) &&
               (is_accel || is_gyro || is_temp);
    restart  = (rec_num_r != in_sequence_word) || (have_r == '0);
    have_fill = restart ? 3'b000 : have_r;
    if (is_accel) begin
      have_fill = have_fill | PART_ACCEL;
    end else if (is_gyro) begin
      have_fill = have_fill | PART_RATE;
    end else begin
      have_fill = have_fill | PART_TEMP;
    end
  end

  // record filing
  always_comb begin
    rec_num_nxt  = rec_num_r;
    rec_ax_nxt   = rec_ax_r;
    rec_ay_nxt   = rec_ay_r;
    rec_az_nxt   = rec_az_r;
    rec_rx_nxt   = rec_rx_r;
    rec_ry_nxt   = rec_ry_r;
    rec_rz_nxt   = rec_rz_r;
    rec_temp_nxt = rec_temp_r;
    have_nxt     = have_r;

    if (cmd.file && frame_ok) begin
      if (restart) begin
        rec_num_nxt  = in_sequence_word;
        rec_ax_nxt   = '0;
        rec_ay_nxt   = '0;
        rec_az_nxt   = '0;
        rec_rx_nxt   = '0;
        rec_ry_nxt   = '0;
        rec_rz_nxt   = '0;
        rec_temp_nxt = '0;
        have_nxt     = '0;
      end
      if (is_accel) begin
        rec_ax_nxt = in_first_word;
        rec_ay_nxt = in_second_word;
        rec_az_nxt = in_third_word;
        have_nxt   = have_nxt | PART_ACCEL;
      end else if (is_gyro) begin
        rec_rx_nxt = in_first_word;
        rec_ry_nxt = in_second_word;
        rec_rz_nxt = in_third_word;
        have_nxt   = have_nxt | PART_RATE;
      end else begin
        rec_temp_nxt = in_first_word;
        have_nxt     = have_nxt | PART_TEMP;
      end
    end else if (cmd.finish) begin
      rec_num_nxt  = '0;
      rec_ax_nxt   = '0;
      rec_ay_nxt   = '0;
      rec_az_nxt   = '0;
      rec_rx_nxt   = '0;
      rec_ry_nxt   = '0;
      rec_rz_nxt   = '0;
      rec_temp_nxt = '0;
      have_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_num_r  <= '0;
      rec_ax_r   <= '0;
      rec_ay_r   <= '0;
      rec_az_r   <= '0;
      rec_rx_r   <= '0;
      rec_ry_r   <= '0;
      rec_rz_r   <= '0;
      rec_temp_r <= '0;
      have_r     <= '0;
    end else begin
      rec_num_r  <= rec_num_nxt;
      rec_ax_r   <= rec_ax_nxt;
      rec_ay_r   <= rec_ay_nxt;
      rec_az_r   <= rec_az_nxt;
      rec_rx_r   <= rec_rx_nxt;
      rec_ry_r   <= rec_ry_nxt;
      rec_rz_r   <= rec_rz_nxt;
      rec_temp_r <= rec_temp_nxt;
      have_r     <= have_nxt;
    end
  end

  // shared multiplier: squares, then threshold products
  always_comb begin
    sq_mag = '0;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.step)
      STEP_SQ_X: sq_mag = mag16(rec_ax_r);
      STEP_SQ_Y: sq_mag = mag16(rec_ay_r);
      STEP_SQ_Z: sq_mag = mag16(rec_az_r);
      default:   sq_mag = '0;
    endcase
    if (cmd.step < STEP_GAP) begin
      mul_a = {{(MulAW-WordW-1){1'b0}}, sq_mag};
      mul_b = {{(MulBW-WordW-1){1'b0}}, sq_mag};
    end else begin
      mul_a = v_r;
      mul_b = tilt_limit(3'(cmd.step - STEP_THR0));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // accumulate from the registered multiplier product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r <= '0;
    end else if (cmd.acc_en) begin
      case (cmd.step)
        STEP_SQ_Y: begin
          h_r    <= prod_r[MulAW-1:0];
          band_r <= '0;
        end
        STEP_SQ_Z: h_r <= h_r + prod_r[MulAW-1:0];
        STEP_GAP:  v_r <= prod_r[MulAW-1:0];
        default: begin
          if ({{(ProdW-MulAW-16){1'b0}}, h_r, 16'b0} >= prod_r) begin
            band_r <= band_r + 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    band_fin = ((h_r == '0) && (v_r == '0)) ? '0 : band_r;
    drop     = 13'(band_fin) * 13'(duty_step_r);
    if (band_fin == '0) begin
      duty_fin = full_duty_r;
    end else if (band_fin >= BAND_MAX) begin
      duty_fin = '0;
    end else if (drop >= 13'(full_duty_r)) begin
      duty_fin = '0;
    end else begin
      duty_fin = full_duty_r - drop[DutyW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_sample_number <= rec_num_r;
      out_accel_x       <= rec_ax_r;
      out_accel_y       <= rec_ay_r;
      out_accel_z       <= rec_az_r;
      out_rate_x        <= rec_rx_r;
      out_rate_y        <= rec_ry_r;
      out_rate_z        <= rec_rz_r;
      out_temp_word     <= rec_temp_r;
      out_tilt_band     <= band_fin;
      out_motor_duty    <= duty_fin;
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.complete = frame_ok && (have_fill == PART_ALL);
  assign sts.out_busy = out_valid_r && out_stall;

endmodule

>>> src/imu_frame_assembler_tilt_duty.sv
// IMU frame assembler with tilt band and motor duty.
// Input channel (in_valid / in_stall): one received CAN frame per word. Standard
// data frames with length code 8 whose identifier matches the accel, gyro or
// temperature register are filed into one record keyed by the sample counter.
// Output channel (out_valid / out_stall): one word per completed record, with
// the sample, a tilt band 0..5 and a duty in permille.
// Configuration (cfg_we / cfg_index / cfg_wdata): identifiers, full duty and
// duty step; write only while the block is idle.
// A frame that does not complete a record leaves the block idle and ready for
// the next frame. A frame that completes one passes the accept, the steps
// through a single shared 32x18 multiplier (three squares, then five threshold
// products, each compared in the following cycle) and the final state, which
// loads the output register and raises out_valid; no input is taken meanwhile.
// A stalled output word holds; the block then waits in its final state and
// takes no input until the output register is free. The output register
// otherwise lets a new frame be accepted while a result still waits.
// Reset (rst_n low, synchronous): record cleared, registers to defaults.
module imu_frame_assembler_tilt_duty (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [imufa_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [imufa_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [imufa_pkg::IdW-1:0]      in_frame_id,
  input  logic                           in_extended_flag,
  input  logic                           in_remote_flag,
  input  logic [3:0]                     in_length_code,
  input  logic [15:0]                    in_sequence_word,
  input  logic signed [15:0]             in_first_word,
  input  logic signed [15:0]             in_second_word,
  input  logic signed [15:0]             in_third_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [15:0]                    out_sample_number,
  output logic signed [15:0]             out_accel_x,
  output logic signed [15:0]             out_accel_y,
  output logic signed [15:0]             out_accel_z,
  output logic signed [15:0]             out_rate_x,
  output logic signed [15:0]             out_rate_y,
  output logic signed [15:0]             out_rate_z,
  output logic signed [15:0]             out_temp_word,
  output logic [imufa_pkg::BandW-1:0]    out_tilt_band,
  output logic [imufa_pkg::DutyW-1:0]    out_motor_duty
);
  import imufa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  imufa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  imufa_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_frame_id       (in_frame_id),
    .in_extended_flag  (in_extended_flag),
    .in_remote_flag    (in_remote_flag),
    .in_length_code    (in_length_code),
    .in_sequence_word  (in_sequence_word),
    .in_first_word     (in_first_word),
    .in_second_word    (in_second_word),
    .in_third_word     (in_third_word),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample_number (out_sample_number),
    .out_accel_x       (out_accel_x),
    .out_accel_y       (out_accel_y),
    .out_accel_z       (out_accel_z),
    .out_rate_x        (out_rate_x),
    .out_rate_y        (out_rate_y),
    .out_rate_z        (out_rate_z),
    .out_temp_word     (out_temp_word),
    .out_tilt_band     (out_tilt_band),
    .out_motor_duty    (out_motor_duty)
  );

endmodule
